>>> rtl/idf_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Integer display formatter package
// Widths, format codes and register indexes shared by the channel
// interfaces, the formatter and its testbench.
// ============================================================================
package idf_pkg;

   localparam int VALUE_WIDTH = 16;
   localparam int CHAR_WIDTH  = 8;

   // Output formats selected by the out_format register.
   typedef enum logic [1:0] {
      MODE_HEX = 2'd0,
      MODE_DEC = 2'd1,
      MODE_BIN = 2'd2,
      MODE_RAW = 2'd3
   } out_format_type;

   // Register indexes; register i sits at byte address 4*i.
   localparam logic [1:0] REG_OUT_FORMAT = 2'd0;
   localparam logic [1:0] REG_WIDE_WORD  = 2'd1;
   localparam logic [1:0] REG_BIT_COUNT  = 2'd2;
   localparam logic [1:0] REG_QUIET      = 2'd3;

endpackage

>>> rtl/idf_req_if.sv
`timescale 1ns / 1ps
// ============================================================================
// Formatter request channel
// Carries one 16-bit value to be formatted per word.
// ============================================================================
interface idf_req_if
   import idf_pkg::*;
   ();

   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);

endinterface

>>> rtl/idf_rsp_if.sv
`timescale 1ns / 1ps
// ============================================================================
// Formatter response channel
// Carries one output character per word and a flag on the final one.
// ============================================================================
interface idf_rsp_if
   import idf_pkg::*;
   ();

   logic                  valid;
   logic                  ready;
   logic [CHAR_WIDTH-1:0] character;
   logic                  last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);

endinterface

>>> rtl/integer_display_formatter_top.sv
`timescale 1ns / 1ps
// ============================================================================
// Integer display formatter
// Turns 16-bit values into streams of ASCII characters (hex, decimal,
// binary) or raw bytes, one character per output word.
// ============================================================================
// Usage:
// A value enters on the request channel when valid and ready are both high.
// After an optional mask to the low bit_count bits it leaves on the response
// channel as a run of characters, one per word, with last set on the final
// one. Hex gives 4 or 6 characters, decimal 1 to 5, binary 10 or 21 and raw
// bytes 1 or 2. With quiet set a value is taken and produces no words.
// A value passes the front stages and the serializer register before its
// first character leaves. The front pipeline takes a new value every cycle
// unless held; throughput is set by the serializer at the end, which sends
// one character per cycle while ready is high and loads the next value as
// the final one is taken; words of consecutive values follow without a gap.
// Registers are written over the APB port; the user must write them only
// while no value is in flight; the block does not enforce it. A synchronous
// reset empties every stage and loads the register reset values (hex, byte
// width, bit count of eight, quiet off). When the receiver holds ready low
// the current character stays on the port, and the stages behind it fill up and hold.
// ============================================================================
module integer_display_formatter_top
   import idf_pkg::*;
   (
   input  logic         clock,
   input  logic         reset,
   idf_req_if.sink      req_ch,
   idf_rsp_if.source    rsp_ch,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [3:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
   );

   // Longest character run of one value (wide binary).
   localparam int MAX_CHARS  = 21;
   localparam int CNT_WIDTH  = $clog2(MAX_CHARS + 1);
   localparam int BCD_WIDTH  = 20;
   localparam int DEC_DIGITS = 5;

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ONE   = 8'h31;
   localparam logic [CHAR_WIDTH-1:0] CHAR_X     = 8'h78;
   localparam logic [CHAR_WIDTH-1:0] CHAR_B     = 8'h62;
   localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE = 8'h20;
   // 'A' minus ten, so that a nibble of ten or more maps onto 'A'..'F'.
   localparam logic [CHAR_WIDTH-1:0] CHAR_ALPHA_BASE = 8'h37;

   // Upper-case hex digit for one nibble.
   function automatic logic [CHAR_WIDTH-1:0] hex_char(input logic [3:0] nib);
      logic [CHAR_WIDTH-1:0] base;
      base = (nib < 4'd10) ? CHAR_ZERO : CHAR_ALPHA_BASE;
      return base + {4'h0, nib};
   endfunction

   // Eight shift-and-add-three steps of the double-dabble conversion,
   // taking the bits of one byte MSB first.
   function automatic logic [BCD_WIDTH-1:0] dabble_byte(input logic [BCD_WIDTH-1:0] bcd_in,
                                                        input logic [7:0]           bits);
      logic [BCD_WIDTH-1:0] acc;
      logic [7:0]           sh;
      acc = bcd_in;
      sh  = bits;
      for (int step = 0; step < 8; step++) begin
         for (int n = 0; n < DEC_DIGITS; n++) begin
            if (acc[4*n +: 4] >= 4'd5) begin
               acc[4*n +: 4] = acc[4*n +: 4] + 4'd3;
            end
         end
         acc = {acc[BCD_WIDTH-2:0], sh[7]};
         sh  = {sh[6:0], 1'b0};
      end
      return acc;
   endfunction

   // ------------------------------------------------------------------------
   // Configuration registers. pready is tied high, so a write completes in
   // its access cycle.
   // ------------------------------------------------------------------------
   out_format_type out_format_ff;
   logic           wide_word_ff;
   logic [4:0]     bit_count_ff;
   logic           quiet_ff;
   logic           csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_format_ff <= MODE_HEX;
         wide_word_ff  <= 1'b0;
         bit_count_ff  <= 5'd8;
         quiet_ff      <= 1'b0;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            REG_OUT_FORMAT: out_format_ff <= out_format_type'(pwdata[1:0]);
            REG_WIDE_WORD:  wide_word_ff  <= pwdata[0];
            REG_BIT_COUNT:  bit_count_ff  <= pwdata[4:0];
            REG_QUIET:      quiet_ff      <= pwdata[0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_OUT_FORMAT: prdata = {30'h0, out_format_ff};
         REG_WIDE_WORD:  prdata = {31'h0, wide_word_ff};
         REG_BIT_COUNT:  prdata = {27'h0, bit_count_ff};
         REG_QUIET:      prdata = {31'h0, quiet_ff};
      endcase
   end

   // ------------------------------------------------------------------------
   // Pipeline handshake. Every stage moves when it is empty or when the
   // stage after it moves, so a stall holds everything in place.
   // ------------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, ser_valid_ff;
   logic s1_ready, s2_ready, s3_ready, s4_ready, ser_ready;
   logic [CNT_WIDTH-1:0] ser_count_ff;
   logic                 ser_final;

   assign ser_final = (ser_count_ff == CNT_WIDTH'(1));
   assign ser_ready = !ser_valid_ff || (rsp_ch.ready && ser_final);
   assign s4_ready  = !s4_valid_ff || ser_ready;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;

   assign req_ch.ready = s1_ready;

   // ------------------------------------------------------------------------
   // Stage 1: mask to bit_count bits, and drop the high byte in byte width.
   // A quiet value is taken and discarded here.
   // ------------------------------------------------------------------------
   logic [VALUE_WIDTH-1:0] keep_mask;
   logic [VALUE_WIDTH-1:0] masked_value;
   logic [VALUE_WIDTH-1:0] s1_value_ff;

   assign keep_mask    = bit_count_ff[4] ? {VALUE_WIDTH{1'b1}}
                       : VALUE_WIDTH'(~({VALUE_WIDTH{1'b1}} << bit_count_ff[3:0]));
   assign masked_value = req_ch.value & keep_mask;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_ch.valid && !quiet_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_value_ff <= wide_word_ff ? masked_value : {8'h00, masked_value[7:0]};
      end
   end

   // ------------------------------------------------------------------------
   // Stages 2 and 3: binary to BCD, the high byte in stage 2 and the low
   // byte in stage 3.
   // ------------------------------------------------------------------------
   logic [VALUE_WIDTH-1:0] s2_value_ff, s3_value_ff;
   logic [BCD_WIDTH-1:0]   s2_bcd_ff, s3_bcd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_value_ff <= s1_value_ff;
         s2_bcd_ff   <= dabble_byte('0, s1_value_ff[15:8]);
      end
      if (s3_ready) begin
         s3_value_ff <= s2_value_ff;
         s3_bcd_ff   <= dabble_byte(s2_bcd_ff, s2_value_ff[7:0]);
      end
   end

   // ------------------------------------------------------------------------
   // Stage 4: lay out the full character run of the value and its length.
   // ------------------------------------------------------------------------
   logic [3:0]            dec_digit [DEC_DIGITS];
   logic [2:0]            dec_top;
   logic [2:0]            dec_lead;
   logic                  dec_seen;
   logic [2:0]            dec_count;
   logic [2:0]            dec_pos [DEC_DIGITS];
   logic [CHAR_WIDTH-1:0] build_char [MAX_CHARS];
   logic [CNT_WIDTH-1:0]  build_count;

   // Decimal: top digit place and the leading zeros to skip. The units
   // digit is always sent.
   always_comb begin
      for (int k = 0; k < DEC_DIGITS; k++) begin
         dec_digit[k] = s3_bcd_ff[4*k +: 4];
      end
      dec_top  = wide_word_ff ? 3'd4 : 3'd2;
      dec_lead = 3'd0;
      dec_seen = 1'b0;
      for (int k = DEC_DIGITS - 1; k >= 1; k--) begin
         if (3'(k) <= dec_top) begin
            if (dec_digit[k] != 4'd0) begin
               dec_seen = 1'b1;
            end else if (!dec_seen) begin
               dec_lead = dec_lead + 3'd1;
            end
         end
      end
      dec_count = dec_top + 3'd1 - dec_lead;
      for (int i = 0; i < DEC_DIGITS; i++) begin
         dec_pos[i] = dec_top - dec_lead - 3'(i);
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_CHARS; i++) begin
         build_char[i] = CHAR_ZERO;
      end
      build_count = '0;
      unique case (out_format_ff)
         MODE_HEX: begin
            build_char[0] = CHAR_ZERO;
            build_char[1] = CHAR_X;
            if (wide_word_ff) begin
               build_char[2] = hex_char(s3_value_ff[15:12]);
               build_char[3] = hex_char(s3_value_ff[11:8]);
               build_char[4] = hex_char(s3_value_ff[7:4]);
               build_char[5] = hex_char(s3_value_ff[3:0]);
               build_count   = CNT_WIDTH'(6);
            end else begin
               build_char[2] = hex_char(s3_value_ff[7:4]);
               build_char[3] = hex_char(s3_value_ff[3:0]);
               build_count   = CNT_WIDTH'(4);
            end
         end
         MODE_DEC: begin
            for (int i = 0; i < DEC_DIGITS; i++) begin
               if (3'(i) < dec_count) begin
                  build_char[i] = CHAR_ZERO | {4'h0, dec_digit[dec_pos[i]]};
               end
            end
            build_count = CNT_WIDTH'(dec_count);
         end
         MODE_BIN: begin
            build_char[0] = CHAR_ZERO;
            build_char[1] = CHAR_B;
            if (wide_word_ff) begin
               for (int i = 0; i < 8; i++) begin
                  build_char[2 + i]  = s3_value_ff[15 - i] ? CHAR_ONE : CHAR_ZERO;
                  build_char[13 + i] = s3_value_ff[7 - i] ? CHAR_ONE : CHAR_ZERO;
               end
               build_char[10] = CHAR_SPACE;
               build_char[11] = CHAR_ZERO;
               build_char[12] = CHAR_B;
               build_count    = CNT_WIDTH'(21);
            end else begin
               for (int i = 0; i < 8; i++) begin
                  build_char[2 + i] = s3_value_ff[7 - i] ? CHAR_ONE : CHAR_ZERO;
               end
               build_count = CNT_WIDTH'(10);
            end
         end
         MODE_RAW: begin
            if (wide_word_ff) begin
               build_char[0] = s3_value_ff[15:8];
               build_char[1] = s3_value_ff[7:0];
               build_count   = CNT_WIDTH'(2);
            end else begin
               build_char[0] = s3_value_ff[7:0];
               build_count   = CNT_WIDTH'(1);
            end
         end
      endcase
   end

   logic [CHAR_WIDTH-1:0] s4_char_ff [MAX_CHARS];
   logic [CNT_WIDTH-1:0]  s4_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (s4_ready) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready) begin
         s4_char_ff  <= build_char;
         s4_count_ff <= build_count;
      end
   end

   // ------------------------------------------------------------------------
   // Serializer: a shift line that presents one character per word. The
   // next run loads in the cycle the final character is taken.
   // ------------------------------------------------------------------------
   logic [CHAR_WIDTH-1:0] ser_char_ff [MAX_CHARS];
   logic                  rsp_take;

   assign rsp_take = ser_valid_ff && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_valid_ff <= 1'b0;
         ser_count_ff <= '0;
      end else if (ser_ready) begin
         ser_valid_ff <= s4_valid_ff;
         ser_count_ff <= s4_count_ff;
      end else if (rsp_take) begin
         ser_count_ff <= ser_count_ff - CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ser_ready) begin
         ser_char_ff <= s4_char_ff;
      end else if (rsp_take) begin
         for (int i = 0; i < MAX_CHARS - 1; i++) begin
            ser_char_ff[i] <= ser_char_ff[i + 1];
         end
         ser_char_ff[MAX_CHARS-1] <= CHAR_ZERO;
      end
   end

   assign rsp_ch.valid     = ser_valid_ff;
   assign rsp_ch.character = ser_char_ff[0];
   assign rsp_ch.last      = ser_final;

endmodule

>>> sim/integer_display_formatter_top_test.sv
`timescale 1ns / 1ps
// ============================================================================
// Integer display formatter testbench
// Drives values into the formatter, predicts the character stream for every
// accepted value from its own copy of the registers, and checks each output
// word in order. Directed cases cover the extremes of every display mode,
// both widths, the edge bit counts and quiet mode. Random traffic then runs
// under four idling patterns with random register settings between groups.
// ============================================================================
module integer_display_formatter_top_test
   import idf_pkg::*;
   ();

   // Register byte addresses on the APB port.
   localparam logic [3:0] ADDR_OUT_FORMAT = {REG_OUT_FORMAT, 2'b00};
   localparam logic [3:0] ADDR_WIDE_WORD  = {REG_WIDE_WORD, 2'b00};
   localparam logic [3:0] ADDR_BIT_COUNT  = {REG_BIT_COUNT, 2'b00};
   localparam logic [3:0] ADDR_QUIET      = {REG_QUIET, 2'b00};

   // ASCII codes that the formatter emits.
   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_ONE   = 8'h31;
   localparam logic [7:0] ASCII_UPPER = 8'h41;
   localparam logic [7:0] ASCII_X     = 8'h78;
   localparam logic [7:0] ASCII_B     = 8'h62;
   localparam logic [7:0] ASCII_SPACE = 8'h20;

   // Cycles allowed after the last expected word before the block counts as
   // idle.
   localparam int DRAIN_CYCLES = 12;

   // Values sent in each random idling phase.
   localparam int PHASE_VALUES = 22;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] character;
      logic                  last;
   } char_word_type;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   idf_req_if req_bus ();
   idf_rsp_if rsp_bus ();

   integer_display_formatter_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_bus),
      .rsp_ch  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Shadow copy of the formatter registers, kept in step with every write.
   out_format_type  cfg_mode;
   logic            cfg_wide;
   logic [4:0]      cfg_bits;
   logic            cfg_quiet;

   // Characters still owed by the formatter, oldest first.
   char_word_type   expected_chars[$];
   logic [7:0]      format_chars[$];

   // Idling of each side, in percent of cycles.
   int              send_idle_pct;
   int              rsp_stall_pct;

   int              fail_count;
   int              values_sent;
   int              chars_checked;

   // The clock runs with a 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Upper-case hex digit for one nibble.
   function automatic logic [7:0] hex_char(input logic [3:0] nibble);
      if (nibble < 4'd10)
         return ASCII_ZERO + {4'd0, nibble};
      return ASCII_UPPER + {4'd0, nibble} - 8'd10;
   endfunction

   // A binary byte is the "0b" prefix followed by its bits, MSB first.
   function automatic void push_bin_byte(input logic [7:0] b);
      format_chars.push_back(ASCII_ZERO);
      format_chars.push_back(ASCII_B);
      for (int k = 7; k >= 0; k--)
         format_chars.push_back(b[k] ? ASCII_ONE : ASCII_ZERO);
   endfunction

   // Works out the character stream of one accepted value under the current
   // register settings and appends it to the expected words.
   function automatic void predict_chars(input logic [VALUE_WIDTH-1:0] raw);
      logic [15:0]   v;
      logic [7:0]    lo;
      logic [7:0]    hi;
      int            place;
      int            digit;
      int            rest;
      bit            started;
      char_word_type w;

      v = raw;
      // Bit counts of sixteen and above leave the value whole; a bit count of
      // zero clears it.
      if (cfg_bits < 5'd16)
         v = raw & ((16'd1 << cfg_bits) - 16'd1);
      lo = v[7:0];
      hi = v[15:8];
      format_chars.delete();

      if (cfg_quiet)
         return;

      case (cfg_mode)
         MODE_HEX: begin
            format_chars.push_back(ASCII_ZERO);
            format_chars.push_back(ASCII_X);
            if (cfg_wide) begin
               format_chars.push_back(hex_char(v[15:12]));
               format_chars.push_back(hex_char(v[11:8]));
            end
            format_chars.push_back(hex_char(lo[7:4]));
            format_chars.push_back(hex_char(lo[3:0]));
         end
         MODE_DEC: begin
            // Leading zeros are dropped, but the units digit always goes out.
            place   = cfg_wide ? 10000 : 100;
            rest    = cfg_wide ? int'(v) : int'(lo);
            started = 1'b0;
            while (place > 1) begin
               digit = rest / place;
               if (started || digit != 0) begin
                  format_chars.push_back(ASCII_ZERO + 8'(digit));
                  rest    = rest - digit * place;
                  started = 1'b1;
               end
               place = place / 10;
            end
            format_chars.push_back(ASCII_ZERO + 8'(rest));
         end
         MODE_BIN: begin
            if (cfg_wide) begin
               push_bin_byte(hi);
               format_chars.push_back(ASCII_SPACE);
            end
            push_bin_byte(lo);
         end
         default: begin
            if (cfg_wide)
               format_chars.push_back(hi);
            format_chars.push_back(lo);
         end
      endcase

      foreach (format_chars[i]) begin
         w.character = format_chars[i];
         w.last      = (i == format_chars.size() - 1);
         expected_chars.push_back(w);
      end
   endfunction

   // Register contents as a read should return them.
   function automatic logic [31:0] register_image(input logic [3:0] addr);
      case (addr)
         ADDR_OUT_FORMAT: return {30'd0, cfg_mode};
         ADDR_WIDE_WORD:  return {31'd0, cfg_wide};
         ADDR_BIT_COUNT:  return {27'd0, cfg_bits};
         default:         return {31'd0, cfg_quiet};
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Configuration port
   // ------------------------------------------------------------------------

   // One APB transfer: a setup cycle, an access cycle, then an idle cycle so
   // that back-to-back transfers never assign psel twice in one time step.
   task automatic apb_transfer(input logic wr, input logic [3:0] addr,
                               input logic [31:0] wdata, output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Reads a register back and compares it with the shadow copy.
   task automatic check_register(input logic [3:0] addr);
      logic [31:0] rdata;
      string       name;

      apb_transfer(1'b0, addr, 32'd0, rdata);
      case (addr)
         ADDR_OUT_FORMAT: name = "out_format";
         ADDR_WIDE_WORD:  name = "wide_word";
         ADDR_BIT_COUNT:  name = "bit_count";
         default:         name = "quiet";
      endcase
      if (rdata !== register_image(addr)) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, register_image(addr), rdata);
         fail_count++;
      end
   endtask

   task automatic write_register(input logic [3:0] addr, input logic [31:0] data);
      logic [31:0] unused;

      apb_transfer(1'b1, addr, data, unused);
      case (addr)
         ADDR_OUT_FORMAT: cfg_mode  = out_format_type'(data[1:0]);
         ADDR_WIDE_WORD:  cfg_wide  = data[0];
         ADDR_BIT_COUNT:  cfg_bits  = data[4:0];
         default:         cfg_quiet = data[0];
      endcase
      check_register(addr);
   endtask

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Drops valid and waits until every expected word has come, then lets the
   // pipeline settle, since a quiet value can still be inside it.
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_chars.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Registers are only written while the formatter is idle.
   task automatic configure(input out_format_type mode, input logic wide,
                            input logic [4:0] bits, input logic quiet);
      wait_for_drain();
      write_register(ADDR_OUT_FORMAT, {30'd0, mode});
      write_register(ADDR_WIDE_WORD, {31'd0, wide});
      write_register(ADDR_BIT_COUNT, {27'd0, bits});
      write_register(ADDR_QUIET, {31'd0, quiet});
   endtask

   // Offers one value and holds it until the formatter takes it. Valid is
   // left high afterwards, so a following value goes out without a gap; it
   // is only lowered when the sender idles or drains.
   task automatic send_value(input logic [VALUE_WIDTH-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= value;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      predict_chars(value);
      values_sent++;
   endtask

   // ------------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------------

   // Every accepted character word is compared with the oldest expectation.
   // The receiver stalls at random according to rsp_stall_pct.
   always @(posedge clock) begin : check_chars
      char_word_type oldest;

      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_chars.size() == 0) begin
            $error("character: expected none, actual 0x%02h (last %0b)",
                   rsp_bus.character, rsp_bus.last);
            fail_count++;
         end else begin
            oldest = expected_chars.pop_front();
            if (rsp_bus.character !== oldest.character) begin
               $error("character: expected 0x%02h, actual 0x%02h",
                      oldest.character, rsp_bus.character);
               fail_count++;
            end
            if (rsp_bus.last !== oldest.last) begin
               $error("last: expected %0b, actual %0b", oldest.last, rsp_bus.last);
               fail_count++;
            end
            chars_checked++;
         end
      end
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Reset values read back, then the default setting formats a byte in hex
   // after masking to eight bits.
   task automatic test_register_reset();
      check_register(ADDR_OUT_FORMAT);
      check_register(ADDR_WIDE_WORD);
      check_register(ADDR_BIT_COUNT);
      check_register(ADDR_QUIET);
      send_value(16'h00A5);
      send_value(16'hFFFF);
   endtask

   task automatic test_hex_format();
      configure(MODE_HEX, 1'b1, 5'd16, 1'b0);
      send_value(16'h0000);
      send_value(16'hFFFF);
      send_value(16'h1A2B);
   endtask

   // Decimal values at the ends of the range and at digit boundaries in both widths.
   task automatic test_decimal_format();
      configure(MODE_DEC, 1'b1, 5'd16, 1'b0);
      send_value(16'd0);
      send_value(16'd65535);
      send_value(16'd10000);
      send_value(16'd9);
      configure(MODE_DEC, 1'b0, 5'd16, 1'b0);
      send_value(16'd255);
      send_value(16'd100);
      send_value(16'h1207);
   endtask

   // Wide binary must send the high byte first, then a space and the low byte.
   task automatic test_binary_format();
      configure(MODE_BIN, 1'b1, 5'd16, 1'b0);
      send_value(16'hA5C3);
      configure(MODE_BIN, 1'b0, 5'd16, 1'b0);
      send_value(16'h7E5A);
   endtask

   task automatic test_raw_format();
      configure(MODE_RAW, 1'b1, 5'd16, 1'b0);
      send_value(16'hFF00);
      configure(MODE_RAW, 1'b0, 5'd16, 1'b0);
      send_value(16'hFF80);
   endtask

   // Raw wide mode shows the mask directly: zero bits clears the value,
   // sixteen and above keep it whole.
   task automatic test_bit_count_limits();
      configure(MODE_RAW, 1'b1, 5'd0, 1'b0);
      send_value(16'hFFFF);
      configure(MODE_RAW, 1'b1, 5'd1, 1'b0);
      send_value(16'hFFFF);
      configure(MODE_RAW, 1'b1, 5'd15, 1'b0);
      send_value(16'hFFFF);
      configure(MODE_RAW, 1'b1, 5'd16, 1'b0);
      send_value(16'hFFFF);
      configure(MODE_RAW, 1'b1, 5'd31, 1'b0);
      send_value(16'hFFFF);
   endtask

   // Quiet values are taken and produce nothing; the next value after quiet
   // is cleared must come out alone.
   task automatic test_quiet_mode();
      configure(MODE_BIN, 1'b1, 5'd16, 1'b1);
      send_value(16'hFFFF);
      send_value(16'h1234);
      configure(MODE_DEC, 1'b0, 5'd8, 1'b0);
      send_value(16'h0001);
   endtask

   // Values biased toward the extremes and the decimal digit boundaries.
   function automatic logic [VALUE_WIDTH-1:0] pick_value();
      case ($urandom_range(6))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(255));
         3:       return 16'($urandom_range(15));
         4: begin
            case ($urandom_range(5))
               0:       return 16'd9;
               1:       return 16'd99;
               2:       return 16'd100;
               3:       return 16'd999;
               4:       return 16'd9999;
               default: return 16'd10000;
            endcase
         end
         default: return 16'($urandom);
      endcase
   endfunction

   // Random groups of values, each under a fresh random register setting, in
   // four idling patterns. Once per pattern the sender also waits until every
   // expected word has come before going on within a group.
   task automatic test_random_traffic();
      int          group_len;
      int          phase_sent;
      int          pause_at;
      logic [4:0]  bits;

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 65; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 65; end
            default: begin send_idle_pct = 30; rsp_stall_pct = 30; end
         endcase
         phase_sent = 0;
         pause_at   = $urandom_range(4, 20);
         while (phase_sent < PHASE_VALUES) begin
            case ($urandom_range(9))
               0:       bits = 5'd0;
               1:       bits = 5'($urandom_range(17, 31));
               2:       bits = 5'd16;
               default: bits = 5'($urandom_range(1, 16));
            endcase
            configure(out_format_type'($urandom_range(3)), 1'($urandom_range(1)), bits,
                      ($urandom_range(7) == 0));
            group_len = $urandom_range(3, 9);
            for (int i = 0; i < group_len && phase_sent < PHASE_VALUES; i++) begin
               if (phase_sent == pause_at)
                  wait_for_drain();
               send_value(pick_value());
               phase_sent++;
            end
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------

   initial begin
      // Every input of the block is known from time zero.
      clock         = 1'b0;
      reset         = 1'b1;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = 4'd0;
      pwdata        = 32'd0;
      req_bus.valid = 1'b0;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      fail_count    = 0;
      values_sent   = 0;
      chars_checked = 0;

      // The shadow registers start at the documented reset values.
      cfg_mode  = MODE_HEX;
      cfg_wide  = 1'b0;
      cfg_bits  = 5'd8;
      cfg_quiet = 1'b0;

      // Reset is held from time zero and released once.
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_reset();
      test_hex_format();
      test_decimal_format();
      test_binary_format();
      test_raw_format();
      test_bit_count_limits();
      test_quiet_mode();
      test_random_traffic();

      // All values are in; wait for the last characters, then a few more
      // cycles in which any stray word would be flagged by the checker.
      wait_for_drain();
      if (expected_chars.size() != 0) begin
         $error("last: %0d expected character words never arrived", expected_chars.size());
         fail_count++;
      end

      $display("Sent %0d values and checked %0d character words across hex, decimal,",
               values_sent, chars_checked);
      $display("binary and raw modes, both widths, edge bit counts and quiet, idle and stalled.");
      if (fail_count == 0)
         $display("integer_display_formatter_top_test passed");
      else
         $display("integer_display_formatter_top_test failed");
      $finish;
   end

   // A hung handshake ends the run long after the slowest correct run would
   // have finished.
   initial begin
      #400000;
      $display("integer_display_formatter_top_test failed");
      $finish;
   end

endmodule
